/* sv/cau_pkg.sv */
// Shared types for the complex arithmetic unit: command codes and the
// per-item control group that travels down the pipeline. No dependencies.
package cau_pkg;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic dz;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
	} item_ctl_t;

endpackage

/* sv/cau_front.sv */
// Front four pipeline stages: products, sums, sign/magnitude and divide setup.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                 clk,
	input  logic [3:0]           en,
	input  logic [1:0]           command,
	input  logic signed [W-1:0]  x_real,
	input  logic signed [W-1:0]  x_imag,
	input  logic signed [W-1:0]  y_real,
	input  logic signed [W-1:0]  y_imag,
	output item_ctl_t            ctl,
	output logic [2*W-1:0]       den,
	output logic [2*W-1:0]       rem_re,
	output logic [2*W-1:0]       rem_im,
	output logic [W-1:0]         low_re,
	output logic [W-1:0]         low_im
);
	localparam int PW = 2*W;
	localparam int SW = 2*W + 1;
	localparam int NW = 2*W + F;
	localparam int HW = W + F;
	localparam int CW = (HW > PW) ? HW : PW;

	// stage 1
	cmd_t                cmd_s1;
	logic signed [PW-1:0] ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;
	logic signed [W:0]    sre_s1, sim_s1;
	// stage 2
	cmd_t                cmd_s2;
	logic signed [SW-1:0] re_s2, im_s2;
	logic [PW-1:0]        den_s2;
	// stage 3
	item_ctl_t            ctl_s3;
	logic [NW-1:0]        val_re_s3, val_im_s3;
	logic [PW-1:0]        den_s3;
	// stage 4
	item_ctl_t            ctl_s4;
	logic [PW-1:0]        den_s4, rem_re_s4, rem_im_s4;
	logic [W-1:0]         low_re_s4, low_im_s4;

	cmd_t                cmd_in;
	logic [W:0]           a_x, b_x, c_x, d_x;
	logic [SW-1:0]        ac_x, bd_x, ad_x, bc_x;
	logic [SW-1:0]        abs_re, abs_im;
	logic [PW-1:0]        mag_re, mag_im;
	logic [NW-1:0]        val_re, val_im;
	logic [HW-1:0]        hi_re, hi_im;
	logic                 is_div3;

	assign cmd_in = cmd_t'(command);
	assign a_x = {x_real[W-1], x_real};
	assign b_x = {x_imag[W-1], x_imag};
	assign c_x = {y_real[W-1], y_real};
	assign d_x = {y_imag[W-1], y_imag};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cmd_s1 <= cmd_in;
			ac_s1  <= x_real * y_real;
			bd_s1  <= x_imag * y_imag;
			ad_s1  <= x_real * y_imag;
			bc_s1  <= x_imag * y_real;
			cc_s1  <= y_real * y_real;
			dd_s1  <= y_imag * y_imag;
			sre_s1 <= (cmd_in == CMD_SUB) ? (a_x - c_x) : (a_x + c_x);
			sim_s1 <= (cmd_in == CMD_SUB) ? (b_x - d_x) : (b_x + d_x);
		end
	end

	assign ac_x = {ac_s1[PW-1], ac_s1};
	assign bd_x = {bd_s1[PW-1], bd_s1};
	assign ad_x = {ad_s1[PW-1], ad_s1};
	assign bc_x = {bc_s1[PW-1], bc_s1};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cmd_s2 <= cmd_s1;
			den_s2 <= cc_s1 + dd_s1;
			case (cmd_s1)
				CMD_MUL: begin
					re_s2 <= ac_x - bd_x;
					im_s2 <= ad_x + bc_x;
				end
				CMD_DIV: begin
					re_s2 <= ac_x + bd_x;
					im_s2 <= bc_x - ad_x;
				end
				default: begin
					re_s2 <= {{W{sre_s1[W]}}, sre_s1};
					im_s2 <= {{W{sim_s1[W]}}, sim_s1};
				end
			endcase
		end
	end

	assign abs_re = re_s2[SW-1] ? -re_s2 : re_s2;
	assign abs_im = im_s2[SW-1] ? -im_s2 : im_s2;
	assign mag_re = abs_re[PW-1:0];
	assign mag_im = abs_im[PW-1:0];

	always_comb begin
		case (cmd_s2)
			CMD_MUL: begin
				val_re = NW'(mag_re) >> F;
				val_im = NW'(mag_im) >> F;
			end
			CMD_DIV: begin
				val_re = NW'(mag_re) << F;
				val_im = NW'(mag_im) << F;
			end
			default: begin
				val_re = NW'(mag_re);
				val_im = NW'(mag_im);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ctl_s3.cmd    <= cmd_s2;
			ctl_s3.dz     <= (cmd_s2 == CMD_DIV) && (den_s2 == '0);
			ctl_s3.neg_re <= re_s2[SW-1];
			ctl_s3.neg_im <= im_s2[SW-1];
			ctl_s3.ovf_re <= 1'b0;
			ctl_s3.ovf_im <= 1'b0;
			val_re_s3     <= val_re;
			val_im_s3     <= val_im;
			den_s3        <= den_s2;
		end
	end

	// quotient of W bits suffices unless the top part already reaches the divisor
	assign hi_re   = val_re_s3[NW-1:W];
	assign hi_im   = val_im_s3[NW-1:W];
	assign is_div3 = (ctl_s3.cmd == CMD_DIV);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ctl_s4.cmd    <= ctl_s3.cmd;
			ctl_s4.dz     <= ctl_s3.dz;
			ctl_s4.neg_re <= ctl_s3.neg_re;
			ctl_s4.neg_im <= ctl_s3.neg_im;
			ctl_s4.ovf_re <= is_div3 && (CW'(hi_re) >= CW'(den_s3));
			ctl_s4.ovf_im <= is_div3 && (CW'(hi_im) >= CW'(den_s3));
			den_s4        <= den_s3;
			rem_re_s4     <= is_div3 ? PW'(hi_re) : val_re_s3[PW-1:0];
			rem_im_s4     <= is_div3 ? PW'(hi_im) : val_im_s3[PW-1:0];
			low_re_s4     <= val_re_s3[W-1:0];
			low_im_s4     <= val_im_s3[W-1:0];
		end
	end

	assign ctl    = ctl_s4;
	assign den    = den_s4;
	assign rem_re = rem_re_s4;
	assign rem_im = rem_im_s4;
	assign low_re = low_re_s4;
	assign low_im = low_im_s4;

endmodule

/* sv/cau_div_stage.sv */
// One restoring-division stage: one quotient bit for each result part.
// Depends on cau_pkg.
module cau_div_stage import cau_pkg::*; #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  item_ctl_t      ctl_in,
	input  logic [2*W-1:0] den_in,
	input  logic [2*W-1:0] rem_re_in,
	input  logic [2*W-1:0] rem_im_in,
	input  logic [W-1:0]   low_re_in,
	input  logic [W-1:0]   low_im_in,
	input  logic [W-1:0]   quo_re_in,
	input  logic [W-1:0]   quo_im_in,
	output item_ctl_t      ctl_out,
	output logic [2*W-1:0] den_out,
	output logic [2*W-1:0] rem_re_out,
	output logic [2*W-1:0] rem_im_out,
	output logic [W-1:0]   low_re_out,
	output logic [W-1:0]   low_im_out,
	output logic [W-1:0]   quo_re_out,
	output logic [W-1:0]   quo_im_out
);
	localparam int PW = 2*W;

	item_ctl_t     ctl_s1;
	logic [PW-1:0] den_s1, rem_re_s1, rem_im_s1;
	logic [W-1:0]  low_re_s1, low_im_s1, quo_re_s1, quo_im_s1;

	logic [PW:0]   step_re, step_im;
	logic          is_div;

	// returns {quotient bit, next remainder}
	function automatic logic [PW:0] div_step(input logic [PW-1:0] rem,
			input logic nbit, input logic [PW-1:0] d);
		logic [PW:0] trial;
		logic [PW:0] diff;
		trial = {rem, nbit};
		diff  = trial - {1'b0, d};
		if (!diff[PW])
			div_step = {1'b1, diff[PW-1:0]};
		else
			div_step = {1'b0, trial[PW-1:0]};
	endfunction

	assign is_div  = (ctl_in.cmd == CMD_DIV);
	assign step_re = div_step(rem_re_in, low_re_in[W-1], den_in);
	assign step_im = div_step(rem_im_in, low_im_in[W-1], den_in);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1    <= ctl_in;
			den_s1    <= den_in;
			low_re_s1 <= low_re_in << 1;
			low_im_s1 <= low_im_in << 1;
			quo_re_s1 <= {quo_re_in[W-2:0], step_re[PW]};
			quo_im_s1 <= {quo_im_in[W-2:0], step_im[PW]};
			// other commands keep their magnitude in the remainder slot
			rem_re_s1 <= is_div ? step_re[PW-1:0] : rem_re_in;
			rem_im_s1 <= is_div ? step_im[PW-1:0] : rem_im_in;
		end
	end

	assign ctl_out    = ctl_s1;
	assign den_out    = den_s1;
	assign rem_re_out = rem_re_s1;
	assign rem_im_out = rem_im_s1;
	assign low_re_out = low_re_s1;
	assign low_im_out = low_im_s1;
	assign quo_re_out = quo_re_s1;
	assign quo_im_out = quo_im_s1;

endmodule

/* sv/cau_back.sv */
// Output stage: magnitude select, saturation, sign restore and flags.
// Depends on cau_pkg.
module cau_back import cau_pkg::*; #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                en,
	input  item_ctl_t           ctl,
	input  logic [2*W-1:0]      rem_re,
	input  logic [2*W-1:0]      rem_im,
	input  logic [W-1:0]        quo_re,
	input  logic [W-1:0]        quo_im,
	output logic signed [W-1:0] res_real,
	output logic signed [W-1:0] res_imag,
	output logic                overflow_flag,
	output logic                div_zero_flag
);
	localparam int PW = 2*W;
	localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W-1);
	localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);
	localparam logic [PW-1:0] BIG     = PW'(1) << W;

	logic [W-1:0]  res_re_q, res_im_q;
	logic          ovf_q, dz_q;

	logic          is_div;
	logic [PW-1:0] mag_re, mag_im, lim_re, lim_im, sat_re_m, sat_im_m;
	logic          sat_re, sat_im;
	logic [W-1:0]  out_re, out_im;

	assign is_div = (ctl.cmd == CMD_DIV);

	always_comb begin
		if (is_div) begin
			mag_re = ctl.ovf_re ? BIG : PW'(quo_re);
			mag_im = ctl.ovf_im ? BIG : PW'(quo_im);
		end else begin
			mag_re = rem_re;
			mag_im = rem_im;
		end
		lim_re   = ctl.neg_re ? LIM_NEG : LIM_POS;
		lim_im   = ctl.neg_im ? LIM_NEG : LIM_POS;
		sat_re   = mag_re > lim_re;
		sat_im   = mag_im > lim_im;
		sat_re_m = sat_re ? lim_re : mag_re;
		sat_im_m = sat_im ? lim_im : mag_im;
		out_re   = ctl.neg_re ? -sat_re_m[W-1:0] : sat_re_m[W-1:0];
		out_im   = ctl.neg_im ? -sat_im_m[W-1:0] : sat_im_m[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= ctl.dz ? '0 : out_re;
			res_im_q <= ctl.dz ? '0 : out_im;
			ovf_q    <= !ctl.dz && (sat_re || sat_im);
			dz_q     <= ctl.dz;
		end
	end

	assign res_real      = res_re_q;
	assign res_imag      = res_im_q;
	assign overflow_flag = ovf_q;
	assign div_zero_flag = dz_q;

endmodule

/* sv/complex_arith_unit.sv */
// Complex add, subtract, multiply and divide on signed fixed-point operands
// (DATA_WIDTH bits, FRAC_BITS fraction bits), saturating with overflow and
// divide-by-zero flags. Takes one request per cycle unless rsp_ready holds
// back the output; the division chain resolves one quotient bit per stage.
// Depends on cau_pkg, cau_front, cau_div_stage and cau_back.
module complex_arith_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [1:0]                   command,
	input  logic signed [DATA_WIDTH-1:0] x_real,
	input  logic signed [DATA_WIDTH-1:0] x_imag,
	input  logic signed [DATA_WIDTH-1:0] y_real,
	input  logic signed [DATA_WIDTH-1:0] y_imag,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic signed [DATA_WIDTH-1:0] res_real,
	output logic signed [DATA_WIDTH-1:0] res_imag,
	output logic                         overflow_flag,
	output logic                         div_zero_flag
);
	localparam int W  = DATA_WIDTH;
	localparam int PW = 2*W;
	localparam int NS = W + 5;

	logic [NS-1:0] vld_q;
	logic [NS:0]   en;

	item_ctl_t     ctl_c [W+1];
	logic [PW-1:0] den_c [W+1];
	logic [PW-1:0] rre_c [W+1];
	logic [PW-1:0] rim_c [W+1];
	logic [W-1:0]  lre_c [W+1];
	logic [W-1:0]  lim_c [W+1];
	logic [W-1:0]  qre_c [W+1];
	logic [W-1:0]  qim_c [W+1];

	// a stage advances when empty or when the one after it advances
	assign en[NS] = rsp_ready;
	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k])
					vld_q[k] <= (k == 0) ? req_valid : vld_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign req_ready = en[0];
	assign rsp_valid = vld_q[NS-1];

	cau_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk     (clk),
		.en      (en[3:0]),
		.command (command),
		.x_real  (x_real),
		.x_imag  (x_imag),
		.y_real  (y_real),
		.y_imag  (y_imag),
		.ctl     (ctl_c[0]),
		.den     (den_c[0]),
		.rem_re  (rre_c[0]),
		.rem_im  (rim_c[0]),
		.low_re  (lre_c[0]),
		.low_im  (lim_c[0])
	);

	assign qre_c[0] = '0;
	assign qim_c[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_div
		cau_div_stage #(.W(W)) u_stage (
			.clk        (clk),
			.en         (en[4+i]),
			.ctl_in     (ctl_c[i]),
			.den_in     (den_c[i]),
			.rem_re_in  (rre_c[i]),
			.rem_im_in  (rim_c[i]),
			.low_re_in  (lre_c[i]),
			.low_im_in  (lim_c[i]),
			.quo_re_in  (qre_c[i]),
			.quo_im_in  (qim_c[i]),
			.ctl_out    (ctl_c[i+1]),
			.den_out    (den_c[i+1]),
			.rem_re_out (rre_c[i+1]),
			.rem_im_out (rim_c[i+1]),
			.low_re_out (lre_c[i+1]),
			.low_im_out (lim_c[i+1]),
			.quo_re_out (qre_c[i+1]),
			.quo_im_out (qim_c[i+1])
		);
	end

	cau_back #(.W(W)) u_back (
		.clk           (clk),
		.en            (en[NS-1]),
		.ctl           (ctl_c[W]),
		.rem_re        (rre_c[W]),
		.rem_im        (rim_c[W]),
		.quo_re        (qre_c[W]),
		.quo_im        (qim_c[W]),
		.res_real      (res_real),
		.res_imag      (res_imag),
		.overflow_flag (overflow_flag),
		.div_zero_flag (div_zero_flag)
	);

endmodule
